>>> design/tlaj_pkg.sv
`default_nettype none
package tlaj_pkg;

  typedef struct packed {
    logic        action;
    logic [15:0] load_angle_first;
    logic [15:0] load_angle_second;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_angle_first;
    logic [15:0] out_angle_second;
    logic [1:0]  step_status;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [17:0] value;
  } cfg_item_t;

  // register indexes
  localparam logic [2:0] CFG_GOAL_X    = 3'd0;
  localparam logic [2:0] CFG_GOAL_Y    = 3'd1;
  localparam logic [2:0] CFG_LINK_1    = 3'd2;
  localparam logic [2:0] CFG_LINK_2    = 3'd3;
  localparam logic [2:0] CFG_STEP_SIZE = 3'd4;
  localparam logic [2:0] CFG_REACH_THR = 3'd5;

  // register reset values
  localparam logic signed [17:0] GOAL_X_RST   = -18'sd2048;
  localparam logic signed [17:0] GOAL_Y_RST   = 18'sd8192;
  localparam logic [15:0]        LINK_1_RST   = 16'd4096;
  localparam logic [15:0]        LINK_2_RST   = 16'd8192;
  localparam logic [12:0]        STEP_RST     = 13'd522;
  localparam logic [16:0]        REACH_RST    = 17'd410;

  // result status
  localparam logic [1:0] ST_LOADED   = 2'd0;
  localparam logic [1:0] ST_MOVED    = 2'd1;
  localparam logic [1:0] ST_REACHED  = 2'd2;
  localparam logic [1:0] ST_SINGULAR = 2'd3;

  // multiplier operation sequence
  localparam logic [4:0] OP_L2C   = 5'd0;
  localparam logic [4:0] OP_L2S   = 5'd1;
  localparam logic [4:0] OP_X     = 5'd2;
  localparam logic [4:0] OP_Y     = 5'd3;
  localparam logic [4:0] OP_DXX   = 5'd4;
  localparam logic [4:0] OP_DYY   = 5'd5;
  localparam logic [4:0] OP_THR   = 5'd6;
  localparam logic [4:0] OP_DET_A = 5'd7;
  localparam logic [4:0] OP_DET_B = 5'd8;
  localparam logic [4:0] OP_V0_A  = 5'd9;
  localparam logic [4:0] OP_V0_B  = 5'd10;
  localparam logic [4:0] OP_V1_A  = 5'd11;
  localparam logic [4:0] OP_V1_B  = 5'd12;
  localparam logic [4:0] OP_M0SQ  = 5'd13;
  localparam logic [4:0] OP_M1SQ  = 5'd14;
  localparam logic [4:0] OP_STEP0 = 5'd15;
  localparam logic [4:0] OP_STEP1 = 5'd16;

  localparam int unsigned ATAN_DEPTH = 24;
  localparam logic signed [19:0] CORDIC_GAIN = 20'sd39797;

  // atan(2^-i) in units of 2^32 per turn
  localparam logic [31:0] ATAN_TURNS [ATAN_DEPTH] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

endpackage
`default_nettype wire

>>> design/tlaj_stream_if.sv
`default_nettype none
interface tlaj_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/two_link_arm_jacobian_step_unit.sv
// Two-link arm inverse-Jacobian step. A load transfer sets both joint angles and
// returns them. A step transfer runs under a small sequencer with one shared 33x33 signed
// multiplier: two CORDIC passes (each after a setup step),
// up to 17 multiplies, normalizing shifts, a square root and two 14-bit restoring
// divisions, ending early when the goal is reached or the arm is singular. The
// input side is busy until the result is placed in the output register; a finished
// result waits in the output register while the next transfer is taken.
`default_nettype none
module two_link_arm_jacobian_step_unit #(
  parameter int unsigned ANGLE_BITS        = 16,
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  tlaj_stream_if.sink   in_i,
  tlaj_stream_if.source out_o,
  tlaj_stream_if.sink   cfg_i
);

  localparam int unsigned ITER = (CORDIC_ITERATIONS < tlaj_pkg::ATAN_DEPTH) ?
                                 CORDIC_ITERATIONS : tlaj_pkg::ATAN_DEPTH;
  localparam int unsigned WIDEN = 32 - ANGLE_BITS;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CINIT  = 9'b000000010,
    S_CORD   = 9'b000000100,
    S_MISSUE = 9'b000001000,
    S_MTAKE  = 9'b000010000,
    S_NORM   = 9'b000100000,
    S_SQRT   = 9'b001000000,
    S_DIV    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

  tlaj_pkg::in_item_t  in_data;
  tlaj_pkg::cfg_item_t cfg_data;
  tlaj_pkg::out_item_t out_data_q, out_data_d;
  logic                out_valid_q, out_valid_d;

  assign in_data  = in_i.data;
  assign cfg_data = cfg_i.data;

  // configuration
  logic signed [17:0] gx_q, gy_q;
  logic [15:0]        l1_q, l2_q;
  logic [12:0]        step_q;
  logic [16:0]        thr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gx_q   <= tlaj_pkg::GOAL_X_RST;
      gy_q   <= tlaj_pkg::GOAL_Y_RST;
      l1_q   <= tlaj_pkg::LINK_1_RST;
      l2_q   <= tlaj_pkg::LINK_2_RST;
      step_q <= tlaj_pkg::STEP_RST;
      thr_q  <= tlaj_pkg::REACH_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_data.index)
        tlaj_pkg::CFG_GOAL_X:    gx_q   <= cfg_data.value;
        tlaj_pkg::CFG_GOAL_Y:    gy_q   <= cfg_data.value;
        tlaj_pkg::CFG_LINK_1:    l1_q   <= cfg_data.value[15:0];
        tlaj_pkg::CFG_LINK_2:    l2_q   <= cfg_data.value[15:0];
        tlaj_pkg::CFG_STEP_SIZE: step_q <= cfg_data.value[12:0];
        tlaj_pkg::CFG_REACH_THR: thr_q  <= cfg_data.value[16:0];
        default: ;
      endcase
    end
  end

  // datapath state
  state_e                  state_q, state_d;
  logic [ANGLE_BITS-1:0]   j1_q, j1_d, j2_q, j2_d;
  logic [4:0]              op_q, op_d;
  logic [5:0]              cnt_q, cnt_d;
  logic                    sel_q, sel_d;
  logic signed [19:0]      cx_q, cx_d, cy_q, cy_d;
  logic signed [32:0]      cz_q, cz_d;
  logic [1:0]              quad_q, quad_d;
  logic signed [19:0]      s1_q, s1_d, c1_q, c1_d, s12_q, s12_d, c12_q, c12_d;
  logic signed [19:0]      l2c_q, l2c_d, l2s_q, l2s_d, px_q, px_d, py_q, py_d;
  logic signed [65:0]      prod_q;
  logic signed [63:0]      acc_q, acc_d;
  logic                    det_neg_q, det_neg_d, det_zero_q, det_zero_d;
  logic                    neg0_q, neg0_d, neg1_q, neg1_d;
  logic [40:0]             m0_q, m0_d, m1_q, m1_d;
  logic [61:0]             sq_v_q, sq_v_d;
  logic [62:0]             sq_res_q, sq_res_d, sq_bit_q, sq_bit_d;
  logic [31:0]             norm_q, norm_d;
  logic [45:0]             rem_q, rem_d;
  logic [13:0]             quo_q, quo_d, d0_q, d0_d;
  logic [15:0]             res_a1_q, res_a1_d, res_a2_q, res_a2_d;
  logic [1:0]              status_q, status_d;

  // shared multiplier
  logic signed [20:0] dx_w, dy_w;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_w;

  assign dx_w = 21'(gx_q) - 21'(px_q);
  assign dy_w = 21'(gy_q) - 21'(py_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_q)
      tlaj_pkg::OP_L2C:   begin mul_a = $signed({17'b0, l2_q}); mul_b = 33'(c12_q); end
      tlaj_pkg::OP_L2S:   begin mul_a = $signed({17'b0, l2_q}); mul_b = 33'(s12_q); end
      tlaj_pkg::OP_X:     begin mul_a = $signed({17'b0, l1_q}); mul_b = 33'(c1_q); end
      tlaj_pkg::OP_Y:     begin mul_a = $signed({17'b0, l1_q}); mul_b = 33'(s1_q); end
      tlaj_pkg::OP_DXX:   begin mul_a = 33'(dx_w); mul_b = 33'(dx_w); end
      tlaj_pkg::OP_DYY:   begin mul_a = 33'(dy_w); mul_b = 33'(dy_w); end
      tlaj_pkg::OP_THR:   begin
        mul_a = $signed({16'b0, thr_q});
        mul_b = $signed({16'b0, thr_q});
      end
      tlaj_pkg::OP_DET_A: begin mul_a = 33'(px_q); mul_b = 33'(l2s_q); end
      tlaj_pkg::OP_DET_B: begin mul_a = 33'(py_q); mul_b = 33'(l2c_q); end
      tlaj_pkg::OP_V0_A:  begin mul_a = 33'(l2c_q); mul_b = 33'(dx_w); end
      tlaj_pkg::OP_V0_B:  begin mul_a = 33'(l2s_q); mul_b = 33'(dy_w); end
      tlaj_pkg::OP_V1_A:  begin mul_a = 33'(px_q); mul_b = 33'(dx_w); end
      tlaj_pkg::OP_V1_B:  begin mul_a = 33'(py_q); mul_b = 33'(dy_w); end
      tlaj_pkg::OP_M0SQ:  begin
        mul_a = $signed({3'b0, m0_q[29:0]});
        mul_b = $signed({3'b0, m0_q[29:0]});
      end
      tlaj_pkg::OP_M1SQ:  begin
        mul_a = $signed({3'b0, m1_q[29:0]});
        mul_b = $signed({3'b0, m1_q[29:0]});
      end
      tlaj_pkg::OP_STEP0: begin
        mul_a = $signed({20'b0, step_q});
        mul_b = $signed({3'b0, m0_q[29:0]});
      end
      tlaj_pkg::OP_STEP1: begin
        mul_a = $signed({20'b0, step_q});
        mul_b = $signed({3'b0, m1_q[29:0]});
      end
      default: ;
    endcase
  end

  assign prod_w = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_w;
  end

  // helpers
  logic [ANGLE_BITS-1:0] ang_w, ld1_w, ld2_w;
  logic [31:0]           a32_w, r32_w;
  logic [1:0]            quad_w;
  logic signed [19:0]    xs_w, ys_w, cx_n, cy_n;
  logic signed [32:0]    cz_n;
  logic [4:0]            it_w;
  logic signed [65:0]    rnd_w;
  logic signed [19:0]    term_w;
  logic signed [63:0]    sum_w, diff_w, vneg_w;
  logic [62:0]           sq_t_w, sq_res_n;
  logic                  sq_ge_w;
  logic [3:0]            k_w;
  logic [45:0]           dsh_w;
  logic [13:0]           quo_n;
  logic [31:0]           j1_sum, j2_sum;

  assign ld1_w  = ANGLE_BITS'(32'(in_data.load_angle_first));
  assign ld2_w  = ANGLE_BITS'(32'(in_data.load_angle_second));
  assign ang_w  = sel_q ? ANGLE_BITS'(j1_q + j2_q) : j1_q;
  assign a32_w  = 32'(ang_w) << WIDEN;
  assign quad_w = 2'((a32_w + 32'h2000_0000) >> 30);
  assign r32_w  = a32_w - {quad_w, 30'b0};

  assign it_w = cnt_q[4:0];
  assign xs_w = cx_q >>> it_w;
  assign ys_w = cy_q >>> it_w;
  always_comb begin
    if (!cz_q[32]) begin
      cx_n = cx_q - ys_w;
      cy_n = cy_q + xs_w;
      cz_n = cz_q - $signed({1'b0, tlaj_pkg::ATAN_TURNS[it_w]});
    end else begin
      cx_n = cx_q + ys_w;
      cy_n = cy_q - xs_w;
      cz_n = cz_q + $signed({1'b0, tlaj_pkg::ATAN_TURNS[it_w]});
    end
  end

  assign rnd_w  = prod_q + 66'sd32768;
  assign term_w = 20'(rnd_w >>> 16);
  assign sum_w  = acc_q + 64'(prod_q);
  assign diff_w = acc_q - 64'(prod_q);
  assign vneg_w = -sum_w;

  assign sq_t_w   = sq_res_q + sq_bit_q;
  assign sq_ge_w  = {1'b0, sq_v_q} >= sq_t_w;
  assign sq_res_n = sq_ge_w ? ((sq_res_q >> 1) + sq_bit_q) : (sq_res_q >> 1);

  assign k_w   = cnt_q[3:0];
  assign dsh_w = 46'({norm_q, 1'b0}) << k_w;
  assign quo_n = (rem_q >= dsh_w) ? (quo_q | (14'd1 << k_w)) : quo_q;

  assign j1_sum = neg0_q ? (32'(j1_q) - 32'(d0_q)) : (32'(j1_q) + 32'(d0_q));
  assign j2_sum = neg1_q ? (32'(j2_q) - 32'(quo_n)) : (32'(j2_q) + 32'(quo_n));

  // sequencer
  always_comb begin
    state_d    = state_q;
    j1_d       = j1_q;
    j2_d       = j2_q;
    op_d       = op_q;
    cnt_d      = cnt_q;
    sel_d      = sel_q;
    cx_d       = cx_q;
    cy_d       = cy_q;
    cz_d       = cz_q;
    quad_d     = quad_q;
    s1_d       = s1_q;
    c1_d       = c1_q;
    s12_d      = s12_q;
    c12_d      = c12_q;
    l2c_d      = l2c_q;
    l2s_d      = l2s_q;
    px_d       = px_q;
    py_d       = py_q;
    acc_d      = acc_q;
    det_neg_d  = det_neg_q;
    det_zero_d = det_zero_q;
    neg0_d     = neg0_q;
    neg1_d     = neg1_q;
    m0_d       = m0_q;
    m1_d       = m1_q;
    sq_v_d     = sq_v_q;
    sq_res_d   = sq_res_q;
    sq_bit_d   = sq_bit_q;
    norm_d     = norm_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    d0_d       = d0_q;
    res_a1_d   = res_a1_q;
    res_a2_d   = res_a2_q;
    status_d   = status_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_o.valid && out_o.ready) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (!in_data.action) begin
            j1_d     = ld1_w;
            j2_d     = ld2_w;
            res_a1_d = 16'(32'(ld1_w));
            res_a2_d = 16'(32'(ld2_w));
            status_d = tlaj_pkg::ST_LOADED;
            state_d  = S_DONE;
          end else begin
            res_a1_d = 16'(32'(j1_q));
            res_a2_d = 16'(32'(j2_q));
            sel_d    = 1'b0;
            state_d  = S_CINIT;
          end
        end
      end
      S_CINIT: begin
        cx_d    = tlaj_pkg::CORDIC_GAIN;
        cy_d    = '0;
        cz_d    = 33'($signed(r32_w));
        quad_d  = quad_w;
        cnt_d   = '0;
        state_d = S_CORD;
      end
      S_CORD: begin
        cx_d  = cx_n;
        cy_d  = cy_n;
        cz_d  = cz_n;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(ITER - 1)) begin
          logic signed [19:0] c_w, s_w;
          case (quad_q)
            2'd0:    begin c_w = cx_n;  s_w = cy_n;  end
            2'd1:    begin c_w = -cy_n; s_w = cx_n;  end
            2'd2:    begin c_w = -cx_n; s_w = -cy_n; end
            default: begin c_w = cy_n;  s_w = -cx_n; end
          endcase
          if (!sel_q) begin
            c1_d    = c_w;
            s1_d    = s_w;
            sel_d   = 1'b1;
            state_d = S_CINIT;
          end else begin
            c12_d   = c_w;
            s12_d   = s_w;
            op_d    = tlaj_pkg::OP_L2C;
            state_d = S_MISSUE;
          end
        end
      end
      S_MISSUE: state_d = S_MTAKE;
      S_MTAKE: begin
        op_d    = op_q + 5'd1;
        state_d = S_MISSUE;
        case (op_q)
          tlaj_pkg::OP_L2C:   l2c_d = term_w;
          tlaj_pkg::OP_L2S:   l2s_d = term_w;
          tlaj_pkg::OP_X:     px_d  = term_w + l2c_q;
          tlaj_pkg::OP_Y:     py_d  = term_w + l2s_q;
          tlaj_pkg::OP_DXX,
          tlaj_pkg::OP_DET_A,
          tlaj_pkg::OP_V0_A,
          tlaj_pkg::OP_V1_A,
          tlaj_pkg::OP_M0SQ:  acc_d = 64'(prod_q);
          tlaj_pkg::OP_DYY:   acc_d = sum_w;
          tlaj_pkg::OP_THR: begin
            if (acc_q < 64'(prod_q)) begin
              status_d = tlaj_pkg::ST_REACHED;
              state_d  = S_DONE;
            end
          end
          tlaj_pkg::OP_DET_B: begin
            det_neg_d  = diff_w[63];
            det_zero_d = (diff_w == '0);
          end
          tlaj_pkg::OP_V0_B: begin
            m0_d   = 41'(sum_w[63] ? vneg_w : sum_w);
            neg0_d = sum_w[63] ^ det_neg_q;
          end
          tlaj_pkg::OP_V1_B: begin
            m1_d   = 41'(vneg_w[63] ? sum_w : vneg_w);
            neg1_d = vneg_w[63] ^ det_neg_q;
            if (det_zero_q || (m0_q == '0 && vneg_w == '0)) begin
              status_d = tlaj_pkg::ST_SINGULAR;
              state_d  = S_DONE;
            end else begin
              state_d = S_NORM;
            end
          end
          tlaj_pkg::OP_M1SQ: begin
            sq_v_d   = 62'(sum_w);
            sq_res_d = '0;
            sq_bit_d = {1'b1, 62'b0};
            cnt_d    = '0;
            state_d  = S_SQRT;
          end
          tlaj_pkg::OP_STEP0,
          tlaj_pkg::OP_STEP1: begin
            op_d    = op_q;
            rem_d   = 46'({prod_q[44:0], 1'b0}) + 46'(norm_q);
            quo_d   = '0;
            cnt_d   = 6'd13;
            state_d = S_DIV;
          end
          default: ;
        endcase
      end
      S_NORM: begin
        // scale both magnitudes together until each fits in 30 bits
        if ((|m0_q[40:30]) || (|m1_q[40:30])) begin
          m0_d = m0_q >> 1;
          m1_d = m1_q >> 1;
        end else begin
          op_d    = tlaj_pkg::OP_M0SQ;
          state_d = S_MISSUE;
        end
      end
      S_SQRT: begin
        if (sq_ge_w) sq_v_d = sq_v_q - sq_t_w[61:0];
        sq_res_d = sq_res_n;
        sq_bit_d = sq_bit_q >> 2;
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          norm_d  = (sq_res_n == '0) ? 32'd1 : sq_res_n[31:0];
          op_d    = tlaj_pkg::OP_STEP0;
          state_d = S_MISSUE;
        end
      end
      S_DIV: begin
        if (rem_q >= dsh_w) rem_d = rem_q - dsh_w;
        quo_d = quo_n;
        cnt_d = cnt_q - 6'd1;
        if (k_w == 4'd0) begin
          if (op_q == tlaj_pkg::OP_STEP0) begin
            d0_d    = quo_n;
            op_d    = tlaj_pkg::OP_STEP1;
            state_d = S_MISSUE;
          end else begin
            j1_d     = j1_sum[ANGLE_BITS-1:0];
            j2_d     = j2_sum[ANGLE_BITS-1:0];
            status_d = tlaj_pkg::ST_MOVED;
            state_d  = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d                 = 1'b1;
          out_data_d.out_angle_first  = res_a1_q;
          out_data_d.out_angle_second = res_a2_q;
          out_data_d.step_status      = status_q;
          state_d                     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      j1_q        <= '0;
      j2_q        <= '0;
      out_valid_q <= 1'b0;
      op_q        <= '0;
      cnt_q       <= '0;
      sel_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      j1_q        <= j1_d;
      j2_q        <= j2_d;
      out_valid_q <= out_valid_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      sel_q       <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    cz_q       <= cz_d;
    quad_q     <= quad_d;
    s1_q       <= s1_d;
    c1_q       <= c1_d;
    s12_q      <= s12_d;
    c12_q      <= c12_d;
    l2c_q      <= l2c_d;
    l2s_q      <= l2s_d;
    px_q       <= px_d;
    py_q       <= py_d;
    acc_q      <= acc_d;
    det_neg_q  <= det_neg_d;
    det_zero_q <= det_zero_d;
    neg0_q     <= neg0_d;
    neg1_q     <= neg1_d;
    m0_q       <= m0_d;
    m1_q       <= m1_d;
    sq_v_q     <= sq_v_d;
    sq_res_q   <= sq_res_d;
    sq_bit_q   <= sq_bit_d;
    norm_q     <= norm_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    d0_q       <= d0_d;
    res_a1_q   <= res_a1_d;
    res_a2_q   <= res_a2_d;
    status_q   <= status_d;
    out_data_q <= out_data_d;
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule
`default_nettype wire

>>> design/tlaj_chk.sv
`default_nettype none
module tlaj_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [33:0] out_data_i
);

  // one item at a time: the input side closes right after a transfer
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input still ready after a transfer");

  // a new result only comes out of a busy cycle
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without work in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("stalled result changed");

endmodule

bind two_link_arm_jacobian_step_unit tlaj_chk u_tlaj_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
`default_nettype wire

>>> test/tlaj_tb_if.sv
`timescale 1ns / 100ps
// Stream interfaces come from the design folder; this file holds the
// testbench-side package with the drain wait and the config value packer.
package tlaj_tb_pkg;

  localparam int unsigned STEP_LATENCY = 2 * 16 + 120;

  function automatic logic [17:0] pack_cfg_value(input int value, input int width);
    logic [17:0] v;
    v = value[17:0];
    if (width < 18) v = v & ((18'd1 << width) - 18'd1);
    return v;
  endfunction
endpackage

>>> test/two_link_arm_jacobian_step_unit_tb.sv
`timescale 1ns / 100ps
module two_link_arm_jacobian_step_unit_tb;

  // index outside the register list
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  logic clk_i;
  logic rst_ni;
  bit   failed;

  tlaj_stream_if #(.T(tlaj_pkg::in_item_t))  in_if ();
  tlaj_stream_if #(.T(tlaj_pkg::out_item_t)) out_if ();
  tlaj_stream_if #(.T(tlaj_pkg::cfg_item_t)) cfg_if ();

  two_link_arm_jacobian_step_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Bit-exact arm model: own copy of joints and registers.
  class arm_scoreboard;
    longint gx, gy, len1, len2, step_len, reach;
    logic [15:0] joint1, joint2;
    tlaj_pkg::out_item_t pending[$];

    function new();
      gx = -2048; gy = 8192; len1 = 4096; len2 = 8192; step_len = 522; reach = 410;
      joint1 = '0; joint2 = '0;
    endfunction

    function void add_expected(tlaj_pkg::out_item_t e);
      pending = {pending, e};
    endfunction

    function void write_reg(logic [2:0] idx, logic [17:0] val);
      case (idx)
        tlaj_pkg::CFG_GOAL_X:    gx = longint'($signed(val));
        tlaj_pkg::CFG_GOAL_Y:    gy = longint'($signed(val));
        tlaj_pkg::CFG_LINK_1:    len1 = val[15:0];
        tlaj_pkg::CFG_LINK_2:    len2 = val[15:0];
        tlaj_pkg::CFG_STEP_SIZE: step_len = val[12:0];
        tlaj_pkg::CFG_REACH_THR: reach = val[16:0];
        default: ;
      endcase
    endfunction

    // >>> on longint floors, which matches the rotator's shifts
    function void rotate(logic [15:0] ang, output longint s, output longint c);
      logic [31:0] a, r;
      logic [1:0]  quad;
      longint x, y, z, xs, ys;
      a = {ang, 16'h0};
      quad = 2'((a + 32'h20000000) >> 30);
      r = a - ({30'd0, quad} << 30);
      z = longint'($signed(r));
      x = 39797; y = 0;
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i; ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= longint'(tlaj_pkg::ATAN_TURNS[i]);
        end else begin
          x += ys; y -= xs; z += longint'(tlaj_pkg::ATAN_TURNS[i]);
        end
      end
      case (quad)
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0; bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv; res = (res >> 1) + bitv;
        end else res >>= 1;
        bitv >>= 2;
      end
      return res;
    endfunction

    function longint link_term(longint len, longint trig);
      return (len * trig + 32768) >>> 16;
    endfunction

    function logic [15:0] scaled(longint unsigned mag, longint unsigned norm);
      longint unsigned num;
      num = longint'(step_len) * mag * 2 + norm;
      return 16'(num / (2 * norm));
    endfunction

    function void note_input(tlaj_pkg::in_item_t it);
      tlaj_pkg::out_item_t e;
      longint s1, c1, s12, c12, l2c, l2s, x, y, dx, dy, det, v0, v1;
      longint unsigned m0, m1, norm;
      logic [15:0] d0, d1;
      e.out_angle_first = joint1;
      e.out_angle_second = joint2;
      if (!it.action) begin
        joint1 = it.load_angle_first; joint2 = it.load_angle_second;
        e.out_angle_first = joint1; e.out_angle_second = joint2;
        e.step_status = tlaj_pkg::ST_LOADED;
        add_expected(e);
        return;
      end
      rotate(joint1, s1, c1);
      rotate(joint1 + joint2, s12, c12);
      l2c = link_term(len2, c12);
      l2s = link_term(len2, s12);
      x = link_term(len1, c1) + l2c;
      y = link_term(len1, s1) + l2s;
      dx = gx - x; dy = gy - y;
      if (dx * dx + dy * dy < reach * reach) begin
        e.step_status = tlaj_pkg::ST_REACHED; add_expected(e); return;
      end
      det = x * l2s - y * l2c;
      v0 = l2c * dx + l2s * dy;
      v1 = -(x * dx + y * dy);
      if (det == 0 || (v0 == 0 && v1 == 0)) begin
        e.step_status = tlaj_pkg::ST_SINGULAR; add_expected(e); return;
      end
      m0 = v0 < 0 ? -v0 : v0;
      m1 = v1 < 0 ? -v1 : v1;
      while (m0 >= (64'd1 << 30) || m1 >= (64'd1 << 30)) begin
        m0 >>= 1; m1 >>= 1;
      end
      norm = floor_sqrt(m0 * m0 + m1 * m1);
      if (norm == 0) norm = 1;
      d0 = scaled(m0, norm);
      d1 = scaled(m1, norm);
      if ((v0 < 0) != (det < 0)) d0 = -d0;
      if ((v1 < 0) != (det < 0)) d1 = -d1;
      joint1 += d0; joint2 += d1;
      e.step_status = tlaj_pkg::ST_MOVED;
      add_expected(e);
    endfunction

    function bit check_result(tlaj_pkg::out_item_t got);
      tlaj_pkg::out_item_t e;
      bit ok;
      ok = 1;
      if (pending.size() == 0) begin
        $error("unexpected result %p", got);
        return 0;
      end
      e = pending.pop_front();
      if (got.out_angle_first !== e.out_angle_first) begin
        $error("out_angle_first exp %0d got %0d", e.out_angle_first, got.out_angle_first);
        ok = 0;
      end
      if (got.out_angle_second !== e.out_angle_second) begin
        $error("out_angle_second exp %0d got %0d", e.out_angle_second, got.out_angle_second);
        ok = 0;
      end
      if (got.step_status !== e.step_status) begin
        $error("step_status exp %0d got %0d", e.step_status, got.step_status);
        ok = 0;
      end
      return ok;
    endfunction
  endclass

  arm_scoreboard arm = new();
  int  long_hold;       // cycles left for the long receiver hold-off
  bit  recv_burst_mode;

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #80_000_000;
    $display("FAIL two_link_arm_jacobian_step_unit");
    $finish;
  end

  // receiver: checks results; random stalls, always ready in burst mode, plus one long hold-off
  initial begin
    out_if.ready = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        if (!arm.check_result(out_if.data)) failed = 1;
      end
      if (long_hold > 0) begin
        long_hold--;
        out_if.ready <= 0;
      end else if (recv_burst_mode) out_if.ready <= 1;
      else out_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // valid is dropped again after each write, so every write lands as a single register update
  task automatic write_reg(logic [2:0] idx, int value, int width);
    tlaj_pkg::cfg_item_t c;
    c.index = idx;
    c.value = tlaj_tb_pkg::pack_cfg_value(value, width);
    cfg_if.valid <= 1;
    cfg_if.data <= c;
    do @(posedge clk_i); while (!cfg_if.ready);
    arm.write_reg(c.index, c.value);
    cfg_if.valid <= 0;
    @(posedge clk_i);
  endtask

  // sender burst/gap pattern; valid stays high across back-to-back transfers
  int burst_left;
  task automatic send_item(logic act, logic [15:0] a1, logic [15:0] a2);
    tlaj_pkg::in_item_t it;
    if (burst_left == 0) begin
      in_if.valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 8);
    end
    it.action = act; it.load_angle_first = a1; it.load_angle_second = a2;
    in_if.valid <= 1;
    in_if.data <= it;
    do @(posedge clk_i); while (!in_if.ready);
    arm.note_input(it);
    burst_left--;
  endtask

  task automatic drain();
    in_if.valid <= 0;
    while (arm.pending.size() != 0) @(posedge clk_i);
    repeat (tlaj_tb_pkg::STEP_LATENCY) @(posedge clk_i);
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(0, 16'($urandom), 16'($urandom));
      else if ($urandom_range(0, 19) == 0)
        send_item(1, 16'($urandom), 16'($urandom));
      else
        send_item(1, 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    rst_ni = 0;
    in_if.valid = 0; in_if.data = '0;
    cfg_if.valid = 0; cfg_if.data = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: loads at extremes, steps at reset settings
    send_item(0, 16'h0000, 16'h0000);
    send_item(1, 16'h1234, 16'h0);
    send_item(0, 16'hFFFF, 16'hFFFF);
    send_item(1, 0, 0);
    send_item(0, 16'h4000, 16'h8000);
    send_item(1, 0, 0);
    send_item(0, 16'h2000, 16'h4000);
    repeat (4) send_item(1, 0, 0);
    drain();
    // singular: zero-length links, with the arm as the earlier steps left it and then folded
    write_reg(tlaj_pkg::CFG_LINK_1, 0, 16);
    write_reg(tlaj_pkg::CFG_LINK_2, 0, 16);
    send_item(1, 0, 0);
    send_item(0, 16'h8000, 16'h8000);
    send_item(1, 0, 0);
    drain();
    write_reg(tlaj_pkg::CFG_LINK_1, 65535, 16);
    write_reg(tlaj_pkg::CFG_LINK_2, 65535, 16);
    write_reg(tlaj_pkg::CFG_GOAL_X, 131071, 18);
    write_reg(tlaj_pkg::CFG_GOAL_Y, -131072, 18);
    write_reg(tlaj_pkg::CFG_STEP_SIZE, 8191, 13);
    write_reg(tlaj_pkg::CFG_REACH_THR, 0, 17);
    send_item(0, 0, 0);
    send_item(1, 0, 0);
    send_item(0, 16'h1000, 16'h3000);
    repeat (3) send_item(1, 0, 0);
    drain();
    // reached: huge threshold, met by the step after the load
    write_reg(tlaj_pkg::CFG_REACH_THR, 131071, 17);
    write_reg(tlaj_pkg::CFG_GOAL_X, -131072, 18);
    write_reg(tlaj_pkg::CFG_GOAL_Y, 131071, 18);
    write_reg(tlaj_pkg::CFG_STEP_SIZE, 0, 13);
    send_item(1, 0, 0);
    send_item(0, 16'h7777, 16'h0101);
    send_item(1, 0, 0);
    drain();

    // long hold-off while the sender keeps offering
    long_hold = 400;
    write_reg(tlaj_pkg::CFG_LINK_1, 4096, 16);
    write_reg(tlaj_pkg::CFG_LINK_2, 8192, 16);
    write_reg(tlaj_pkg::CFG_GOAL_X, 3000, 18);
    write_reg(tlaj_pkg::CFG_GOAL_Y, 6000, 18);
    write_reg(tlaj_pkg::CFG_STEP_SIZE, 522, 13);
    write_reg(tlaj_pkg::CFG_REACH_THR, 410, 17);
    random_phase(200);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(tlaj_pkg::CFG_GOAL_X, $urandom_range(0, 262143) - 131072, 18);
      write_reg(tlaj_pkg::CFG_GOAL_Y, int'($urandom_range(0, 40000)) - 20000, 18);
      write_reg(tlaj_pkg::CFG_LINK_1, $urandom_range(0, 65535), 16);
      write_reg(tlaj_pkg::CFG_LINK_2, $urandom_range(0, 65535), 16);
      write_reg(tlaj_pkg::CFG_STEP_SIZE, $urandom_range(0, 8191), 13);
      write_reg(tlaj_pkg::CFG_REACH_THR, $urandom_range(0, 3) == 0 ?
                $urandom_range(0, 131071) : $urandom_range(0, 2000), 17);
      // also touch an out-of-range index, which must be ignored
      write_reg(CFG_UNUSED, $urandom, 18);
      recv_burst_mode = (ph == 2);
      random_phase(100);
      drain();
    end
    recv_burst_mode = 0;

    if (!failed)
      $display("PASS two_link_arm_jacobian_step_unit");
    else
      $display("FAIL two_link_arm_jacobian_step_unit");
    $finish;
  end
endmodule

>>> files.f
design/tlaj_pkg.sv
design/tlaj_stream_if.sv
design/two_link_arm_jacobian_step_unit.sv
design/tlaj_chk.sv
test/tlaj_tb_if.sv
test/two_link_arm_jacobian_step_unit_tb.sv
